// ===== rtl/lst_pkg.sv =====
// shared types, function codes and helpers for the lru session table
package lst_pkg;

  localparam logic [1:0] FN_ACCESS = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] session_key;
  } lst_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    logic [63:0] evicted_key;
    logic        removed;
    logic [4:0]  occupancy;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] create_count;
  } lst_out_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] stamp;
  } lst_entry_t;

  // what the scan found
  typedef struct packed {
    logic match_hit;
    logic old_hit;
    logic free_hit;
  } lst_found_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/lst_mem.sv =====
// key and stamp ram, one write port and one registered read port
module lst_mem import lst_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  lst_entry_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output lst_entry_t    rdata
);

  lst_entry_t mem [DEPTH];
  lst_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lst_scan.sv =====
// walks the entries one per cycle: key match, oldest valid entry, first free slot
module lst_scan import lst_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          rd_vld,
  input  logic [AW-1:0] rd_idx,
  input  logic          rd_valid_bit,
  input  lst_entry_t    rd_entry,
  input  logic [63:0]   search_key,
  output lst_found_t    found,
  output logic [AW-1:0] match_idx,
  output logic [AW-1:0] old_idx,
  output logic [63:0]   old_key,
  output logic [AW-1:0] free_idx
);

  lst_found_t    found_r, found_nxt;
  logic [AW-1:0] match_idx_r, old_idx_r, free_idx_r;
  logic [63:0]   old_key_r, old_stamp_r;
  logic          take_match, take_old, take_free;

  always_comb begin
    take_match = rd_vld && rd_valid_bit && !found_r.match_hit &&
                 (rd_entry.key == search_key);
    // strict compare keeps the lowest slot among equal stamps
    take_old   = rd_vld && rd_valid_bit &&
                 (!found_r.old_hit || (rd_entry.stamp < old_stamp_r));
    take_free  = rd_vld && !rd_valid_bit && !found_r.free_hit;
    found_nxt  = found_r;
    if (take_match) found_nxt.match_hit = 1'b1;
    if (take_old)   found_nxt.old_hit   = 1'b1;
    if (take_free)  found_nxt.free_hit  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (clr) begin
      found_r <= '0;
    end else begin
      found_r <= found_nxt;
    end
    if (take_match) match_idx_r <= rd_idx;
    if (take_old) begin
      old_idx_r   <= rd_idx;
      old_key_r   <= rd_entry.key;
      old_stamp_r <= rd_entry.stamp;
    end
    if (take_free) free_idx_r <= rd_idx;
  end

  assign found     = found_r;
  assign match_idx = match_idx_r;
  assign old_idx   = old_idx_r;
  assign old_key   = old_key_r;
  assign free_idx  = free_idx_r;

endmodule

// ===== rtl/lru_session_table.sv =====
// lru session table: access and delete pass through the scan, drain and update states before out_valid
// clear and the unused code skip the scan and go straight to update; one word in flight at a time
// the scan reads one ram entry per cycle, and a new word is taken only once busy drops
// out_valid pulses for one cycle, the receiver cannot stall
// synchronous reset empties the table, zeroes the counters and the use clock, limit 16
module lru_session_table import lst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lst_in_t    in_data,
  output logic       out_valid,
  output lst_out_t   out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_UPD} state_t;

  state_t        state_r, state_nxt;
  lst_in_t       item_r;
  logic [4:0]    max_r;
  logic [AW-1:0] addr_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [63:0]   clock_r, clock_nxt;
  logic [31:0]   hits_r, misses_r, evicts_r, creates_r;
  logic [31:0]   hits_nxt, misses_nxt, evicts_nxt, creates_nxt;
  logic          out_valid_r;
  lst_out_t      out_r, out_nxt;

  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  lst_entry_t    mem_wdata, mem_rdata;
  lst_found_t    found;
  logic [AW-1:0] match_idx, old_idx, free_idx;
  logic [63:0]   old_key;

  logic [4:0]    lim5;
  logic [LW-1:0] limit;
  logic          full, do_evict, do_ins;
  logic [AW-1:0] ins_idx, slot_c;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign mem_re = (state_r == ST_SCAN);

  lst_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  lst_scan #(.AW(AW)) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr          (accept),
    .rd_vld       (rd_vld_r),
    .rd_idx       (rd_idx_r),
    .rd_valid_bit (valid_r[rd_idx_r]),
    .rd_entry     (mem_rdata),
    .search_key   (item_r.session_key),
    .found        (found),
    .match_idx    (match_idx),
    .old_idx      (old_idx),
    .old_key      (old_key),
    .free_idx     (free_idx)
  );

  always_comb begin
    // zero acts as one, anything above the table size as the table size
    lim5  = (max_r == 5'd0) ? 5'd1 : max_r;
    limit = (LW'(lim5) > LW'(SLOTS)) ? LW'(SLOTS) : LW'(lim5);
    full  = (LW'(occ_r) >= limit);

    do_evict = full && found.old_hit;
    if (do_evict) begin
      do_ins  = 1'b1;
      ins_idx = (found.free_hit && (free_idx < old_idx)) ? free_idx : old_idx;
    end else begin
      do_ins  = found.free_hit;
      ins_idx = free_idx;
    end

    state_nxt   = state_r;
    valid_nxt   = valid_r;
    occ_nxt     = occ_r;
    clock_nxt   = clock_r;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    evicts_nxt  = evicts_r;
    creates_nxt = creates_r;
    mem_we      = 1'b0;
    mem_waddr   = ins_idx;
    mem_wdata   = '{key: item_r.session_key, stamp: clock_r};
    slot_c      = '0;
    out_nxt     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if ((in_data.func == FN_ACCESS) || (in_data.func == FN_DELETE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_SCAN: begin
        if (addr_r == AW'(SLOTS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        case (item_r.func)
          FN_ACCESS: begin
            if (found.match_hit) begin
              mem_we      = 1'b1;
              mem_waddr   = match_idx;
              clock_nxt   = clock_r + 64'd1;
              hits_nxt    = sat_inc(hits_r);
              out_nxt.hit = 1'b1;
              slot_c      = match_idx;
            end else begin
              misses_nxt = sat_inc(misses_r);
              if (do_evict) begin
                valid_nxt[old_idx]  = 1'b0;
                evicts_nxt          = sat_inc(evicts_r);
                out_nxt.evicted     = 1'b1;
                out_nxt.evicted_key = old_key;
              end
              if (do_ins) begin
                valid_nxt[ins_idx] = 1'b1;
                mem_we             = 1'b1;
                clock_nxt          = clock_r + 64'd1;
                creates_nxt        = sat_inc(creates_r);
                slot_c             = ins_idx;
              end
              // eviction and insert together leave the count unchanged
              if (do_ins && !do_evict) occ_nxt = occ_r + CW'(1);
              if (do_evict && !do_ins) occ_nxt = occ_r - CW'(1);
            end
          end
          FN_DELETE: begin
            if (found.match_hit) begin
              valid_nxt[match_idx] = 1'b0;
              occ_nxt              = occ_r - CW'(1);
              out_nxt.removed      = 1'b1;
              slot_c               = match_idx;
            end
          end
          FN_CLEAR: begin
            valid_nxt = '0;
            occ_nxt   = '0;
          end
          default: begin
          end
        endcase
        out_nxt.slot           = 4'(slot_c);
        out_nxt.occupancy      = 5'(occ_nxt);
        out_nxt.hit_count      = hits_nxt;
        out_nxt.miss_count     = misses_nxt;
        out_nxt.eviction_count = evicts_nxt;
        out_nxt.create_count   = creates_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_r       <= 5'd16;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      clock_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      creates_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      clock_r     <= clock_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      creates_r   <= creates_nxt;
      rd_vld_r    <= mem_re;
      out_valid_r <= (state_r == ST_UPD);
      if (cfg_we) max_r <= cfg_wdata;
      if (accept) begin
        addr_r <= '0;
      end else if (mem_re) begin
        addr_r <= addr_r + AW'(1);
      end
    end
    if (accept) item_r <= in_data;
    rd_idx_r <= addr_r;
    if (state_r == ST_UPD) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CW'($countones(valid_r)))
    else $error("occupancy count disagrees with valid bits");

  a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> out_valid)
    else $error("update cycle not followed by a result word");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_UPD))
    else $error("ram written outside the update cycle");

endmodule
